FILE: src/akru_pkg.sv
// ============================================================================
// akru_pkg: shared types and codes for the ray update engine
// Beat layouts, function codes and fixed-point limits.
// ============================================================================
`default_nettype none

package akru_pkg;

    // Slave-side beat layout
    localparam int FUNC_W      = 2;
    localparam int IDXF_W      = 12;
    localparam int VAL_W       = 32;
    localparam int WGT_W       = 24;
    localparam int S_TDATA_W   = 104;

    // Master-side beat layout
    localparam int M_TDATA_W   = 40;

    typedef logic [FUNC_W-1:0] func_t;

    localparam func_t FUNC_LOAD = 2'd0;
    localparam func_t FUNC_RAY  = 2'd1;
    localparam func_t FUNC_READ = 2'd2;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_RAY  = 1'b1;

    // Index of the last quotient step of the restoring divider
    localparam logic [6:0] DIV_LAST = 7'd95;

    // Accumulator limits
    localparam logic [63:0] NORM_CAP = 64'h4000_0000_0000_0000;
    localparam logic signed [65:0] S64_MAX = 66'sh0_7fff_ffff_ffff_ffff;

endpackage

`default_nettype wire

FILE: src/art_kaczmarz_ray_update.sv
// ============================================================================
// art_kaczmarz_ray_update: algebraic reconstruction ray update engine
// Grid of signed Q16.16 cells in block RAM, updated one ray at a time.
// ============================================================================
// Usage:
//   Slave channel (s_*): one beat per command; s_tuser selects load (0),
//   ray entry (1) or read (2); s_tlast marks the last entry of a ray.
//   Master channel (m_*): read data (m_tuser 0) or ray done (m_tuser 1).
//   Config channel (cfg_*): positive_only, always ready; write when idle.
// Sequence:
//   Load writes the grid at the handshake; a read registers the grid word
//   and loads the output register once it is free. Ray entry: grid read,
//   multiply, accumulate. Ray end: residual, the one-bit-per-cycle divider,
//   then per buffered entry a buffer read, a grid read with multiply and a
//   grid write, then the result is posted; a zero norm goes straight to the
//   result. The single grid RAM port pair and serial divider set this order.
// Reset: the grid is swept to zero, one cell a cycle, with s_tready low.
//   The ray buffer is not cleared.
// Stall: a result waits in the output register; a new command is still
//   taken, and the engine holds only when it has a second result to post.
// ============================================================================
`default_nettype none

module art_kaczmarz_ray_update #(
    parameter int GRID_CELLS      = 4096,
    parameter int MAX_RAY_ENTRIES = 256
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // slave beat
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata: cell_index[11:0], cell_value[43:12], weight[67:44],
    //        measurement[99:68], zero pad[103:100]
    input  wire logic [akru_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser: func[1:0]
    input  wire logic [akru_pkg::FUNC_W-1:0]    s_tuser,
    input  wire logic                           s_tlast,
    // master beat
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata: read_value[31:0], norm_zero[32], ray_overflow[33], zero pad[39:34]
    output logic [akru_pkg::M_TDATA_W-1:0]      m_tdata,
    // tuser: result_kind[0]
    output logic                                m_tuser,
    // config write
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic                           cfg_data
);
    import akru_pkg::*;

    localparam int IDX_W  = $clog2(GRID_CELLS);
    localparam int BUF_AW = $clog2(MAX_RAY_ENTRIES);
    localparam int CNT_W  = BUF_AW + 1;
    localparam int BUF_W  = IDX_W + WGT_W;
    localparam logic [31:0] RECIP   = 32'((1 << 24) / GRID_CELLS);
    localparam logic [31:0] CELLS32 = 32'(GRID_CELLS);

    localparam logic [3:0] ST_CLR     = 4'd0;
    localparam logic [3:0] ST_IDLE    = 4'd1;
    localparam logic [3:0] ST_RD_OUT  = 4'd2;
    localparam logic [3:0] ST_ACC1    = 4'd3;
    localparam logic [3:0] ST_ACC2    = 4'd4;
    localparam logic [3:0] ST_FIN     = 4'd5;
    localparam logic [3:0] ST_DIV     = 4'd6;
    localparam logic [3:0] ST_UPD_RD  = 4'd7;
    localparam logic [3:0] ST_UPD_MUL = 4'd8;
    localparam logic [3:0] ST_UPD_WR  = 4'd9;
    localparam logic [3:0] ST_RAY_OUT = 4'd10;

    // saturate to 32 bits, then optional clamp at zero
    function automatic logic [31:0] fit_cell(input logic signed [57:0] v, input logic pos);
        logic [31:0] r;
        if (v > 58'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -58'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        if (pos && r[31])
            r = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    logic [3:0]        state_reg, state_next;
    logic              pos_reg;
    logic [IDX_W-1:0]  clr_reg, clr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [63:0]       norm_reg, norm_next;
    logic signed [63:0] proj_reg, proj_next;
    logic              ovf_reg, ovf_next;

    // captured command fields
    logic [WGT_W-1:0]  in_w_reg;
    logic [VAL_W-1:0]  in_meas_reg;
    logic              in_last_reg;

    // datapath registers
    logic signed [56:0] prod_reg, prod_next;
    logic [47:0]        sq_reg, sq_next;
    logic               neg_reg, neg_next;
    logic [95:0]        dvd_reg, dvd_next;
    logic [63:0]        rem_reg, rem_next;
    logic [63:0]        q_reg, q_next;
    logic               sat_reg, sat_next;
    logic [6:0]         dcnt_reg, dcnt_next;
    logic [30:0]        th_reg, th_next;
    logic [31:0]        tl_reg, tl_next;
    logic [54:0]        phi_reg, phi_next;
    logic [55:0]        plo_reg, plo_next;
    logic [IDX_W-1:0]   uidx_reg, uidx_next;

    // output register
    logic               m_valid_reg;
    logic               m_kind_reg;
    logic [31:0]        m_value_reg;
    logic               m_nz_reg;
    logic               m_ovf_reg;
    logic               out_load;
    logic               out_kind;
    logic [31:0]        out_value;
    logic               out_nz;
    logic               out_ovf;

    // memories
    logic [31:0]        grid_mem [GRID_CELLS];
    logic [BUF_W-1:0]   buf_mem [MAX_RAY_ENTRIES];
    logic               grid_we, grid_re;
    logic [IDX_W-1:0]   grid_wa, grid_ra;
    logic [31:0]        grid_wd, grid_q;
    logic               buf_we, buf_re;
    logic [BUF_AW-1:0]  buf_wa, buf_ra;
    logic [BUF_W-1:0]   buf_wd, buf_q;

    // ------------------------------------------------------------------
    // Beat fields and index wrap
    // ------------------------------------------------------------------
    logic [IDXF_W-1:0]  s_cidx;
    logic [VAL_W-1:0]   s_cval;
    logic [WGT_W-1:0]   s_wgt;
    logic               s_hs;
    logic [39:0]        wrap_prod;
    logic [31:0]        wrap_q;
    logic [31:0]        wrap_qg;
    logic [31:0]        wrap_r;
    logic [31:0]        wrap_rf;
    logic [IDX_W-1:0]   s_idx;

    assign s_cidx = s_tdata[11:0];
    assign s_cval = s_tdata[43:12];
    assign s_wgt  = s_tdata[67:44];
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_hs      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // index mod GRID_CELLS by reciprocal multiply and one correction
    always_comb
    begin
        wrap_prod = 40'({28'b0, s_cidx}) * 40'(RECIP);
        wrap_q    = 32'(wrap_prod[35:24]);
        wrap_qg   = wrap_q * CELLS32;
        wrap_r    = 32'({20'b0, s_cidx}) - wrap_qg;
        wrap_rf   = (wrap_r >= CELLS32) ? (wrap_r - CELLS32) : wrap_r;
        s_idx     = IDX_W'(wrap_rf);
    end

    // ------------------------------------------------------------------
    // Memories: registered read ports
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (grid_we)
            grid_mem[grid_wa] <= grid_wd;
        if (grid_re)
            grid_q <= grid_mem[grid_ra];
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[buf_wa] <= buf_wd;
        if (buf_re)
            buf_q <= buf_mem[buf_ra];
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [63:0]         norm_sum;
    logic signed [64:0]  proj_sum;
    logic signed [47:0]  meas_sh;
    logic signed [65:0]  res_raw, res_sat;
    logic [62:0]         res_mag;
    logic [63:0]         rem_sh;
    logic [63:0]         t_fin;
    logic [55:0]         delta;
    logic signed [57:0]  cell_new;
    logic                out_free;

    always_comb
    begin
        norm_sum = norm_reg + 64'(sq_reg);
        proj_sum = 65'(proj_reg) + 65'(prod_reg);
        meas_sh  = {in_meas_reg, 16'b0};
        res_raw  = 66'(meas_sh) - 66'(proj_reg);
        if (res_raw > S64_MAX)
            res_sat = S64_MAX;
        else if (res_raw < -S64_MAX)
            res_sat = -S64_MAX;
        else
            res_sat = res_raw;
        res_mag  = res_sat[65] ? 63'(-res_sat) : res_sat[62:0];
        rem_sh   = {rem_reg[62:0], dvd_reg[95]};
        delta    = 56'(phi_reg) + 56'(plo_reg[55:32]);
        cell_new = neg_reg ? (58'($signed(grid_q)) - $signed({2'b0, delta}))
                           : (58'($signed(grid_q)) + $signed({2'b0, delta}));
        out_free = !m_valid_reg || m_tready;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        count_next = count_reg;
        k_next     = k_reg;
        norm_next  = norm_reg;
        proj_next  = proj_reg;
        ovf_next   = ovf_reg;
        prod_next  = prod_reg;
        sq_next    = sq_reg;
        neg_next   = neg_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        sat_next   = sat_reg;
        dcnt_next  = dcnt_reg;
        th_next    = th_reg;
        tl_next    = tl_reg;
        phi_next   = phi_reg;
        plo_next   = plo_reg;
        uidx_next  = uidx_reg;
        t_fin      = '0;
        grid_we    = 1'b0;
        grid_wa    = s_idx;
        grid_wd    = '0;
        grid_re    = 1'b0;
        grid_ra    = s_idx;
        buf_we     = 1'b0;
        buf_wa     = count_reg[BUF_AW-1:0];
        buf_wd     = {s_wgt, s_idx};
        buf_re     = 1'b0;
        buf_ra     = k_reg[BUF_AW-1:0];
        out_load   = 1'b0;
        out_kind   = KIND_RAY;
        out_value  = '0;
        out_nz     = 1'b0;
        out_ovf    = 1'b0;

        unique case (state_reg)
            ST_CLR:
            begin
                grid_we  = 1'b1;
                grid_wa  = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(GRID_CELLS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_hs)
                begin
                    unique case (s_tuser)
                        FUNC_LOAD:
                        begin
                            grid_we = 1'b1;
                            grid_wd = fit_cell(58'($signed(s_cval)), pos_reg);
                        end
                        FUNC_RAY:
                        begin
                            if (count_reg < CNT_W'(MAX_RAY_ENTRIES))
                            begin
                                grid_re    = 1'b1;
                                buf_we     = 1'b1;
                                state_next = ST_ACC1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                                if (s_tlast)
                                    state_next = ST_FIN;
                            end
                        end
                        FUNC_READ:
                        begin
                            grid_re    = 1'b1;
                            state_next = ST_RD_OUT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_RD_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_READ;
                    out_value  = grid_q;
                    state_next = ST_IDLE;
                end
            end
            // weight products
            ST_ACC1:
            begin
                prod_next  = $signed({1'b0, in_w_reg}) * $signed(grid_q);
                sq_next    = in_w_reg * in_w_reg;
                state_next = ST_ACC2;
            end
            // saturating accumulation
            ST_ACC2:
            begin
                norm_next = (norm_sum > NORM_CAP) ? NORM_CAP : norm_sum;
                if (proj_sum > 65'(S64_MAX))
                    proj_next = S64_MAX[63:0];
                else if (proj_sum < -65'(S64_MAX))
                    proj_next = 64'(-S64_MAX);
                else
                    proj_next = proj_sum[63:0];
                count_next = count_reg + 1'b1;
                state_next = in_last_reg ? ST_FIN : ST_IDLE;
            end
            // residual and divider setup, or straight to the result on zero norm
            ST_FIN:
            begin
                if (norm_reg == '0)
                    state_next = ST_RAY_OUT;
                else
                begin
                    neg_next   = res_sat[65];
                    dvd_next   = {1'b0, res_mag, 32'b0};
                    rem_next   = '0;
                    q_next     = '0;
                    sat_next   = 1'b0;
                    dcnt_next  = '0;
                    state_next = ST_DIV;
                end
            end
            // restoring division, one quotient bit per cycle
            ST_DIV:
            begin
                dvd_next = {dvd_reg[94:0], 1'b0};
                if (q_reg[63:62] != 2'b00)
                    sat_next = 1'b1;
                if (rem_sh >= norm_reg)
                begin
                    rem_next = rem_sh - norm_reg;
                    q_next   = {q_reg[62:0], 1'b1};
                end
                else
                begin
                    rem_next = rem_sh;
                    q_next   = {q_reg[62:0], 1'b0};
                end
                dcnt_next = dcnt_reg + 1'b1;
                if (dcnt_reg == DIV_LAST)
                begin
                    t_fin      = (sat_next || q_next[63]) ? S64_MAX[63:0] : q_next;
                    th_next    = t_fin[62:32];
                    tl_next    = t_fin[31:0];
                    k_next     = '0;
                    state_next = ST_UPD_RD;
                end
            end
            ST_UPD_RD:
            begin
                buf_re     = 1'b1;
                state_next = ST_UPD_MUL;
            end
            ST_UPD_MUL:
            begin
                grid_re    = 1'b1;
                grid_ra    = buf_q[IDX_W-1:0];
                uidx_next  = buf_q[IDX_W-1:0];
                phi_next   = buf_q[BUF_W-1:IDX_W] * th_reg;
                plo_next   = buf_q[BUF_W-1:IDX_W] * tl_reg;
                state_next = ST_UPD_WR;
            end
            ST_UPD_WR:
            begin
                grid_we = 1'b1;
                grid_wa = uidx_reg;
                grid_wd = fit_cell(cell_new, pos_reg);
                k_next  = k_reg + 1'b1;
                state_next = (k_reg + 1'b1 == count_reg) ? ST_RAY_OUT : ST_UPD_RD;
            end
            ST_RAY_OUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    out_kind   = KIND_RAY;
                    out_nz     = (norm_reg == '0);
                    out_ovf    = ovf_reg;
                    count_next = '0;
                    norm_next  = '0;
                    proj_next  = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            clr_reg     <= '0;
            count_reg   <= '0;
            k_reg       <= '0;
            norm_reg    <= '0;
            proj_reg    <= '0;
            ovf_reg     <= 1'b0;
            pos_reg     <= 1'b0;
            dcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            norm_reg  <= norm_next;
            proj_reg  <= proj_next;
            ovf_reg   <= ovf_next;
            dcnt_reg  <= dcnt_next;
            if (cfg_valid && cfg_ready)
                pos_reg <= cfg_data;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_hs)
        begin
            in_w_reg    <= s_wgt;
            in_meas_reg <= s_tdata[99:68];
            in_last_reg <= s_tlast;
        end
        prod_reg <= prod_next;
        sq_reg   <= sq_next;
        neg_reg  <= neg_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        sat_reg  <= sat_next;
        th_reg   <= th_next;
        tl_reg   <= tl_next;
        phi_reg  <= phi_next;
        plo_reg  <= plo_next;
        uidx_reg <= uidx_next;
        if (out_load)
        begin
            m_kind_reg  <= out_kind;
            m_value_reg <= out_value;
            m_nz_reg    <= out_nz;
            m_ovf_reg   <= out_ovf;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tdata  = {6'b0, m_ovf_reg, m_nz_reg, m_value_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RAY_ENTRIES))
        else $error("ray entry count beyond buffer depth");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (norm_reg != '0))
        else $error("divider running on zero norm");

    a_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
        (grid_we && state_reg == ST_IDLE) |-> (s_hs && s_tuser == FUNC_LOAD))
        else $error("grid written in idle without a load beat");

    a_update_in_ray: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_UPD_WR) |-> (k_reg < count_reg))
        else $error("update walked past buffered entries");

endmodule

`default_nettype wire

FILE: dv/art_kaczmarz_ray_update_chk.sv
// ============================================================================
// art_kaczmarz_ray_update_chk: result checker for the ray update engine
// Watches the command, result and config channels, keeps its own grid and
// ray state, predicts each result beat and compares it field by field.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module art_kaczmarz_ray_update_chk (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [akru_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [akru_pkg::FUNC_W-1:0]    s_tuser,
    input  wire logic                           s_tlast,
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [akru_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic                           m_tuser,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic                           cfg_data,
    output int                                  errors,
    output int                                  pending
);
    import akru_pkg::*;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic        nzero;
        logic        ovf;
    } outcome_t;

    localparam int CELLS = 4096;
    localparam int RAY_MAX = 256;
    localparam logic signed [63:0] P_MAX = 64'sh7fff_ffff_ffff_ffff;

    logic signed [31:0] grid [CELLS];
    logic [11:0]        ray_cell [RAY_MAX];
    logic [23:0]        ray_wgt [RAY_MAX];
    int                 ray_len;
    logic [63:0]        norm_acc;
    logic signed [63:0] proj_acc;
    logic               ray_ovf;
    logic               clamp_neg;
    outcome_t           outcomes_due[$];

    function automatic logic signed [63:0] sat_sum(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'(P_MAX))
            return P_MAX;
        if (s < -65'(P_MAX))
            return -P_MAX;
        return s[63:0];
    endfunction

    function automatic logic signed [31:0] fit(logic signed [63:0] v);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        if (clamp_neg && v < 0)
            v = 0;
        return v[31:0];
    endfunction

    // floor(mag * 2^32 / d) capped to the positive 64-bit limit
    function automatic logic [63:0] quotient_q32(logic [63:0] mag, logic [63:0] d);
        logic [127:0] q;
        q = {mag, 32'd0} / {64'd0, d};
        if (q > 128'(P_MAX))
            return P_MAX;
        return q[63:0];
    endfunction

    // apply one accepted command beat, queue its result if any
    task automatic take_cmd(logic [FUNC_W-1:0] fn, logic [S_TDATA_W-1:0] d,
                            logic lst);
        logic [11:0]        idx;
        logic [23:0]        w;
        logic signed [63:0] r, dl;
        logic [63:0]        mag, t;
        logic [127:0]       prod;
        logic               neg;
        outcome_t           o;
        idx = d[11:0];
        w   = d[67:44];
        o   = '0;
        case (fn)
            FUNC_LOAD:
                grid[idx] = fit(64'(signed'(d[43:12])));
            FUNC_READ:
            begin
                o.kind  = KIND_READ;
                o.value = grid[idx];
                outcomes_due = {outcomes_due, o};
            end
            FUNC_RAY:
            begin
                if (ray_len < RAY_MAX)
                begin
                    ray_cell[ray_len] = idx;
                    ray_wgt[ray_len]  = w;
                    ray_len++;
                    norm_acc = norm_acc + 64'(w) * 64'(w);
                    if (norm_acc > NORM_CAP)
                        norm_acc = NORM_CAP;
                    proj_acc = sat_sum(proj_acc,
                        64'(signed'({1'b0, w})) * 64'(grid[idx]));
                end
                else
                    ray_ovf = 1'b1;
                if (lst)
                begin
                    o.kind = KIND_RAY;
                    o.ovf  = ray_ovf;
                    if (norm_acc == 0)
                        o.nzero = 1'b1;
                    else
                    begin
                        r   = sat_sum(64'(signed'(d[99:68])) * 64'sd65536, -proj_acc);
                        neg = r < 0;
                        mag = neg ? -r : r;
                        t   = quotient_q32(mag, norm_acc);
                        for (int k = 0; k < ray_len; k++)
                        begin
                            prod = 128'(ray_wgt[k]) * 128'(t);
                            dl   = prod[95:32];
                            grid[ray_cell[k]] = fit(64'(grid[ray_cell[k]]) +
                                                    (neg ? -dl : dl));
                        end
                    end
                    outcomes_due = {outcomes_due, o};
                    ray_len  = 0;
                    norm_acc = 0;
                    proj_acc = 0;
                    ray_ovf  = 0;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t got, want;
        if (!rst_n)
        begin
            foreach (grid[i])
                grid[i] = '0;
            ray_len   = 0;
            norm_acc  = '0;
            proj_acc  = '0;
            ray_ovf   = 1'b0;
            clamp_neg = 1'b0;
            errors    = 0;
            outcomes_due.delete();
            pending   = 0;
        end
        else
        begin
            // result beat first: it was formed before this cycle's command
            if (m_tvalid && m_tready)
            begin
                got = '{m_tuser, m_tdata[31:0], m_tdata[32], m_tdata[33]};
                if (outcomes_due.size() == 0)
                begin
                    $display("%0t: unexpected result beat exp none act %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = outcomes_due.pop_front();
                    if (got.kind !== want.kind || got.value !== want.value ||
                        got.nzero !== want.nzero || got.ovf !== want.ovf ||
                        m_tdata[39:34] !== '0)
                    begin
                        $display("%0t: result mismatch exp kind=%0d val=%h nz=%0d ovf=%0d",
                                 $time, want.kind, want.value, want.nzero, want.ovf);
                        $display("%0t:                 act kind=%0d val=%h nz=%0d ovf=%0d",
                                 $time, got.kind, got.value, got.nzero, got.ovf);
                        errors++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                clamp_neg = cfg_data;
            if (s_tvalid && s_tready)
                take_cmd(s_tuser, s_tdata, s_tlast);
            pending = outcomes_due.size();
        end
    end

endmodule

`default_nettype wire

FILE: dv/art_kaczmarz_ray_update_tb.sv
// ============================================================================
// art_kaczmarz_ray_update_tb: stimulus and verdict for the ray update engine
// Directed loads, reads, rays and a reserved code, then random loads, reads, reserved codes and
// rays with random gaps on both sides, across positive_only settings; the checker module judges results.
// ============================================================================
`timescale 1ns / 100ps
`default_nettype none

module art_kaczmarz_ray_update_tb;
    import akru_pkg::*;

    localparam int IDLE_LIMIT = 200000;

    // reserved function code, must be ignored
    localparam func_t FUNC_BAD = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]    s_tuser;
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic                 cfg_data;
    int                   errors;
    int                   pending;
    int                   quiet_cycles;

    art_kaczmarz_ray_update i_dut (.*);

    art_kaczmarz_ray_update_chk i_chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // send one command beat, with a random gap before it
    task automatic send(func_t fn, logic [11:0] idx, logic [31:0] val,
                        logic [23:0] w, logic [31:0] meas, logic lst);
        repeat ($urandom_range(0, 16)) @(negedge clk);
        s_tvalid = 1'b1;
        s_tuser  = fn;
        s_tdata  = {4'd0, meas, w, val, idx};
        s_tlast  = lst;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        s_tvalid = 1'b0;
    endtask

    task automatic set_clamp(logic v);
        while (pending != 0) @(negedge clk);
        repeat (2000) @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h000f_ffff);
            3: return -$urandom_range(0, 32'h000f_ffff);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] rnd_wgt();
        case ($urandom_range(0, 4))
            0: return 24'hff_ffff;
            1: return 24'd0;
            2: return 24'($urandom_range(0, 24'h02_0000));
            default: return 24'($urandom);
        endcase
    endfunction

    // cells mostly in a small region
    function automatic logic [11:0] rnd_cell();
        if ($urandom_range(0, 1) == 1)
            return 12'($urandom_range(0, 63));
        return 12'($urandom);
    endfunction

    // one ray of n entries
    task automatic send_ray(int n);
        for (int k = 0; k < n; k++)
            send(FUNC_RAY, rnd_cell(), $urandom, rnd_wgt(), rnd_val(), k == n - 1);
    endtask

    // result side: a random wait before taking each beat
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            repeat ($urandom_range(0, 16)) @(negedge clk);
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            @(negedge clk);
            m_tready = 1'b0;
        end
    end

    // watchdog on cycles with no beat accepted
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > IDLE_LIMIT)
        begin
            $display("[art_kaczmarz_ray_update] ERROR");
            $finish;
        end
    end

    initial
    begin
        int n;
        int len;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_LOAD;
        s_tlast  = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = 1'b0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // directed: extremes, every function, zero norm, mid-ray access
        send(FUNC_LOAD, 12'd0, 32'h7fff_ffff, '0, '0, 1'b0);
        send(FUNC_LOAD, 12'hfff, 32'h8000_0000, '0, '0, 1'b0);
        send(FUNC_READ, 12'd0, '0, '0, '0, 1'b0);
        send(FUNC_READ, 12'hfff, '0, '0, '0, 1'b0);
        send(FUNC_RAY, 12'd5, '0, 24'd0, 32'd100, 1'b1);
        send(FUNC_RAY, 12'd0, '0, 24'hff_ffff, '0, 1'b0);
        send(FUNC_LOAD, 12'd1, 32'h0001_0000, '0, '0, 1'b0);
        send(FUNC_READ, 12'd1, '0, '0, '0, 1'b0);
        send(FUNC_RAY, 12'hfff, '0, 24'hff_ffff, 32'h7fff_ffff, 1'b1);
        send(FUNC_RAY, 12'd1, '0, 24'd1, 32'h8000_0000, 1'b1);
        send(FUNC_BAD, 12'hfff, 32'hffff_ffff, 24'hff_ffff, 32'hffff_ffff, 1'b1);
        send(FUNC_READ, 12'd0, '0, '0, '0, 1'b0);
        send(FUNC_READ, 12'hfff, '0, '0, '0, 1'b0);
        set_clamp(1'b1);
        send(FUNC_LOAD, 12'd2, 32'hffff_0000, '0, '0, 1'b0);
        send(FUNC_READ, 12'd2, '0, '0, '0, 1'b0);
        send(FUNC_RAY, 12'd3, '0, 24'h01_0000, 32'h8000_0000, 1'b1);
        send(FUNC_READ, 12'd3, '0, '0, '0, 1'b0);
        // overflowing ray: buffer full, extras dropped
        send_ray(260);
        set_clamp(1'b0);

        // random phases across clamp settings, about 250 beats each
        for (int ph = 0; ph < 4; ph++)
        begin
            n = 0;
            while (n < 250)
            begin
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        send(FUNC_LOAD, 12'($urandom), rnd_val(), 24'($urandom),
                             $urandom, 1'($urandom));
                        n += 1;
                    end
                    2, 3:
                    begin
                        send(FUNC_READ, rnd_cell(), $urandom, 24'($urandom),
                             $urandom, 1'($urandom));
                        n += 1;
                    end
                    4:
                    begin
                        send(FUNC_BAD, 12'($urandom), $urandom, 24'($urandom),
                             $urandom, 1'($urandom));
                        n += 1;
                    end
                    default:
                    begin
                        len = int'($urandom_range(1, 6));
                        send_ray(len);
                        n += len;
                    end
                endcase
            end
            set_clamp(ph[0] == 0);
        end

        while (pending != 0) @(negedge clk);
        repeat (2000) @(negedge clk);
        if (errors == 0)
            $display("[art_kaczmarz_ray_update] OK");
        else
            $display("[art_kaczmarz_ray_update] ERROR");
        $finish;
    end

endmodule

`default_nettype wire
